// ===== design/assert_macros.svh =====
// Assertion helpers used by the RTL. Simulation gets the checks and
// synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HMN_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define HMN_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define HMN_ASSERT(lbl, clk, rst, prop)
`define HMN_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== design/hmn_pkg.sv =====
package hmn_pkg;

   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_LENGTH = 256;

   // Edge vector components entering the unit-vector engine.
   localparam int P_W = 18;
   // Grid size registers and point counters.
   localparam int CW = 9;

   localparam logic [1:0] CMD_WRITE  = 2'd0;
   localparam logic [1:0] CMD_READ_H = 2'd1;
   localparam logic [1:0] CMD_READ_N = 2'd2;
   localparam logic [1:0] CMD_NONE   = 2'd3;

   localparam logic [0:0] REG_GRID_WIDTH  = 1'b0;
   localparam logic [0:0] REG_GRID_LENGTH = 1'b1;

   localparam logic [CW-1:0] GRID_RESET = 9'd256;

   typedef struct packed {
      logic signed [15:0] uz;
      logic signed [15:0] uy;
      logic signed [15:0] ux;
   } unit_res_type;

endpackage

// ===== design/hmn_unit.sv =====
module hmn_unit import hmn_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic signed [P_W-1:0] p,
   input  logic signed [P_W-1:0] q,
   output logic                  done,
   output unit_res_type          res
);

   typedef enum logic [10:0] {
      U_IDLE = 11'b00000000001,
      U_SQP  = 11'b00000000010,
      U_SQQ  = 11'b00000000100,
      U_SADD = 11'b00000001000,
      U_DIV  = 11'b00000010000,
      U_RMUL = 11'b00000100000,
      U_RCMP = 11'b00001000000,
      U_MX   = 11'b00010000000,
      U_MY   = 11'b00100000000,
      U_MZ   = 11'b01000000000,
      U_FIN  = 11'b10000000000
   } ustate_type;

   localparam logic [5:0] DIV_TOP  = 6'd60;
   localparam logic [4:0] ROOT_TOP = 5'd22;

   ustate_type         state_ff, state_in;
   logic signed [23:0] p_ff, p_in, q_ff, q_in;
   logic signed [47:0] prod_ff, prod_in;
   logic signed [23:0] mul_a, mul_b;
   logic [35:0]        s_ff, s_in;
   logic [36:0]        rem_ff, rem_in;
   logic [44:0]        quo_ff, quo_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [4:0]         bit_ff, bit_in;
   logic [22:0]        r_ff, r_in;
   logic [22:0]        cand;
   logic [36:0]        sh;
   logic               ge;
   logic               done_ff, done_in;
   unit_res_type       res_ff, res_in;

   // Round half away from zero after dropping 18 fraction bits.
   function automatic logic signed [15:0] rnd18(input logic signed [47:0] v);
      logic [47:0] mag;
      logic [47:0] m;
      mag = v[47] ? 48'(-v) : 48'(v);
      m = (mag + 48'h20000) >> 18;
      return v[47] ? 16'(-m) : 16'(m);
   endfunction

   assign cand = r_ff | (23'd1 << bit_ff);
   assign sh   = {rem_ff[35:0], (cnt_ff == DIV_TOP)};
   assign ge   = sh >= {1'b0, s_ff};

   always_comb begin
      case (state_ff)
         U_SQP: begin
            mul_a = p_ff;
            mul_b = p_ff;
         end
         U_SQQ: begin
            mul_a = q_ff;
            mul_b = q_ff;
         end
         U_RMUL: begin
            mul_a = {1'b0, cand};
            mul_b = {1'b0, cand};
         end
         U_MX: begin
            mul_a = p_ff;
            mul_b = {1'b0, r_ff};
         end
         U_MY: begin
            mul_a = 24'sd256;
            mul_b = {1'b0, r_ff};
         end
         U_MZ: begin
            mul_a = q_ff;
            mul_b = {1'b0, r_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_comb begin
      state_in = state_ff;
      p_in     = p_ff;
      q_in     = q_ff;
      s_in     = s_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      bit_in   = bit_ff;
      r_in     = r_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      case (state_ff)
         U_IDLE: begin
            if (start) begin
               p_in     = 24'(p);
               q_in     = 24'(q);
               state_in = U_SQP;
            end
         end
         U_SQP: state_in = U_SQQ;
         U_SQQ: begin
            s_in     = prod_ff[35:0];
            state_in = U_SADD;
         end
         U_SADD: begin
            s_in     = s_ff + prod_ff[35:0] + 36'd65536;
            rem_in   = '0;
            quo_in   = '0;
            cnt_in   = DIV_TOP;
            state_in = U_DIV;
         end
         U_DIV: begin
            rem_in = ge ? sh - {1'b0, s_ff} : sh;
            quo_in = {quo_ff[43:0], ge};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == '0) begin
               r_in     = '0;
               bit_in   = ROOT_TOP;
               state_in = U_RMUL;
            end
         end
         U_RMUL: state_in = U_RCMP;
         U_RCMP: begin
            if (prod_ff[46:0] <= {2'b00, quo_ff}) begin
               r_in = cand;
            end
            if (bit_ff == '0) begin
               state_in = U_MX;
            end else begin
               bit_in   = bit_ff - 5'd1;
               state_in = U_RMUL;
            end
         end
         U_MX: state_in = U_MY;
         U_MY: begin
            res_in.ux = rnd18(prod_ff);
            state_in  = U_MZ;
         end
         U_MZ: begin
            res_in.uy = rnd18(prod_ff);
            state_in  = U_FIN;
         end
         U_FIN: begin
            res_in.uz = rnd18(prod_ff);
            done_in   = 1'b1;
            state_in  = U_IDLE;
         end
         default: state_in = U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      p_ff    <= p_in;
      q_ff    <= q_in;
      prod_ff <= prod_in;
      s_ff    <= s_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      bit_ff  <= bit_in;
      r_ff    <= r_in;
      res_ff  <= res_in;
   end

   assign done = done_ff;
   assign res  = res_ff;

endmodule

// ===== design/heightmap_normal_grid_core.sv =====
// Height write, height read and normal read with current normals pass through the
// fetch and response states; a beat outside the grid goes straight to the response
// state. A new beat is taken only once the last result is in the output register.
// A normal read inside the grid after a write or a size change first recomputes all
// normals with the shared unit-vector engine.
// Synchronous active-high reset marks the normals stale; memories keep their data.
`include "assert_macros.svh"

module heightmap_normal_grid_core import hmn_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_LENGTH = DEF_MAX_LENGTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // command[1:0], col[9:2], row[17:10], height_in[33:18], zero fill above
   input  logic [39:0]   req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // status[0], height_out[16:1], normal_x[32:17], normal_y[48:33],
   // normal_z[64:49], zero fill above
   output logic [71:0]   rsp_tdata,
   input  logic          csr_we,
   input  logic [0:0]    csr_addr,
   input  logic [CW-1:0] csr_wdata
);

   localparam int DEPTH = MAX_WIDTH * MAX_LENGTH;
   localparam int AW    = $clog2(DEPTH);

   // One-hot sequencer. The first pass builds rough normals point by point;
   // the second pass smooths them.
   typedef enum logic [10:0] {
      S_IDLE     = 11'b00000000001,
      S_FETCH    = 11'b00000000010,
      S_RESP     = 11'b00000000100,
      S_P1_ADDR  = 11'b00000001000,
      S_P1_DATA  = 11'b00000010000,
      S_P1_UNIT  = 11'b00000100000,
      S_P1_WAIT  = 11'b00001000000,
      S_P1_STORE = 11'b00010000000,
      S_P2_ADDR  = 11'b00100000000,
      S_P2_DATA  = 11'b01000000000,
      S_P2_STORE = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration and staleness.
   logic [CW-1:0] grid_width_ff, grid_width_in;
   logic [CW-1:0] grid_length_ff, grid_length_in;
   logic          current_ff, current_in;
   logic [CW-1:0] w_eff, l_eff;

   // Latched request.
   logic [1:0]        cmd_ff, cmd_in;
   logic [7:0]        col_ff, col_in;
   logic [7:0]        row_ff, row_in;
   logic [15:0]       hin_ff, hin_in;
   logic              oob_ff, oob_in;
   logic              req_oob;
   logic              req_fire;

   // Pass counters.
   logic [CW-1:0] x_ff, x_in, z_ff, z_in;
   logic [2:0]    nb_ff, nb_in;
   logic [1:0]    cj_ff, cj_in;
   logic          up_ok, dn_ok, lf_ok, rt_ok, nb_ok;

   // Working values of the passes.
   logic signed [15:0] nh_ff [5];
   logic signed [15:0] nh_in [5];
   logic signed [15:0] acc_ff [3];
   logic signed [15:0] acc_in [3];
   logic signed [17:0] t_ff [3];
   logic signed [17:0] t_in [3];
   logic signed [16:0] da, db, dc, dd;
   logic signed [P_W-1:0] cp, cq;
   logic               corner_ok;
   logic               unit_start, unit_done;
   unit_res_type       unit_res;

   // Memories and their ports.
   logic [15:0] height_mem [DEPTH];
   logic [47:0] rough_mem [DEPTH];
   logic [47:0] smooth_mem [DEPTH];
   logic [AW-1:0] req_addr, pt_addr, nb_addr;
   logic [15:0]   h_rdata_ff;
   logic [47:0]   r_rdata_ff, s_rdata_ff;
   logic [47:0]   smooth_wdata;
   logic          h_we, h_re, r_re, s_re;
   logic [AW-1:0] h_raddr;

   // Output register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic [71:0]   rsp_data_ff, rsp_data_in;
   logic          rsp_load;

   // Sizes beyond the memory act as the memory size.
   assign w_eff = (32'(grid_width_ff) > MAX_WIDTH) ? CW'(MAX_WIDTH) : grid_width_ff;
   assign l_eff = (32'(grid_length_ff) > MAX_LENGTH) ? CW'(MAX_LENGTH) : grid_length_ff;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_oob    = ({1'b0, req_tdata[9:2]} >= w_eff) ||
                       ({1'b0, req_tdata[17:10]} >= l_eff);

   assign req_addr = AW'(row_ff) * AW'(MAX_WIDTH) + AW'(col_ff);
   assign pt_addr  = AW'(z_ff) * AW'(MAX_WIDTH) + AW'(x_ff);

   assign up_ok = (z_ff != '0);
   assign lf_ok = (x_ff != '0);
   assign dn_ok = ({1'b0, z_ff} + 10'd1) < {1'b0, l_eff};
   assign rt_ok = ({1'b0, x_ff} + 10'd1) < {1'b0, w_eff};

   // Neighbor order: own, up, left, down, right. A missing neighbor reads the
   // own point and is masked later.
   always_comb begin
      case (nb_ff)
         3'd0: begin
            nb_ok   = 1'b1;
            nb_addr = pt_addr;
         end
         3'd1: begin
            nb_ok   = up_ok;
            nb_addr = up_ok ? pt_addr - AW'(MAX_WIDTH) : pt_addr;
         end
         3'd2: begin
            nb_ok   = lf_ok;
            nb_addr = lf_ok ? pt_addr - AW'(1) : pt_addr;
         end
         3'd3: begin
            nb_ok   = dn_ok;
            nb_addr = dn_ok ? pt_addr + AW'(MAX_WIDTH) : pt_addr;
         end
         3'd4: begin
            nb_ok   = rt_ok;
            nb_addr = rt_ok ? pt_addr + AW'(1) : pt_addr;
         end
         default: begin
            nb_ok   = 1'b0;
            nb_addr = pt_addr;
         end
      endcase
   end

   // Edge differences, neighbor minus own, zero where the edge is missing.
   assign da = up_ok ? {nh_ff[1][15], nh_ff[1]} - {nh_ff[0][15], nh_ff[0]} : '0;
   assign db = lf_ok ? {nh_ff[2][15], nh_ff[2]} - {nh_ff[0][15], nh_ff[0]} : '0;
   assign dc = dn_ok ? {nh_ff[3][15], nh_ff[3]} - {nh_ff[0][15], nh_ff[0]} : '0;
   assign dd = rt_ok ? {nh_ff[4][15], nh_ff[4]} - {nh_ff[0][15], nh_ff[0]} : '0;

   // The four corner cross products: up-left, left-down, down-right and
   // right-up, each of the form (p, 256, q).
   always_comb begin
      case (cj_ff)
         2'd0: begin
            cp        = P_W'(db);
            cq        = P_W'(da);
            corner_ok = lf_ok && up_ok;
         end
         2'd1: begin
            cp        = P_W'(db);
            cq        = -P_W'(dc);
            corner_ok = lf_ok && dn_ok;
         end
         2'd2: begin
            cp        = -P_W'(dd);
            cq        = -P_W'(dc);
            corner_ok = rt_ok && dn_ok;
         end
         default: begin
            cp        = -P_W'(dd);
            cq        = P_W'(da);
            corner_ok = rt_ok && up_ok;
         end
      endcase
   end

   assign unit_start = (state_ff == S_P1_UNIT) && corner_ok;

   hmn_unit u_unit (
      .clock (clock),
      .reset (reset),
      .start (unit_start),
      .p     (cp),
      .q     (cq),
      .done  (unit_done),
      .res   (unit_res)
   );

   // Smoothed normal: the sum is in Q.12, rounded half away from zero to Q5.10.
   // The sum stays within six rough normals, so the result always fits.
   always_comb begin
      logic [17:0] mag;
      logic [17:0] m;
      logic [15:0] comp [3];
      for (int k = 0; k < 3; k++) begin
         mag     = t_ff[k][17] ? 18'(-t_ff[k]) : 18'(t_ff[k]);
         m       = (mag + 18'd2) >> 2;
         comp[k] = t_ff[k][17] ? 16'(-m) : 16'(m);
      end
      if (t_ff[0] == '0 && t_ff[1] == '0 && t_ff[2] == '0) begin
         smooth_wdata = {16'd0, 16'd2048, 16'd0};
      end else begin
         smooth_wdata = {comp[2], comp[1], comp[0]};
      end
   end

   assign h_we    = (state_ff == S_FETCH) && (cmd_ff == CMD_WRITE);
   assign h_re    = (state_ff == S_FETCH) || (state_ff == S_P1_ADDR);
   assign h_raddr = (state_ff == S_FETCH) ? req_addr : nb_addr;
   assign r_re    = (state_ff == S_P2_ADDR);
   assign s_re    = (state_ff == S_FETCH);

   always_ff @(posedge clock) begin
      if (h_we) begin
         height_mem[req_addr] <= hin_ff;
      end
      if (h_re) begin
         h_rdata_ff <= height_mem[h_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_P1_STORE) begin
         rough_mem[pt_addr] <= {acc_ff[2], acc_ff[1], acc_ff[0]};
      end
      if (r_re) begin
         r_rdata_ff <= rough_mem[nb_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_P2_STORE) begin
         smooth_mem[pt_addr] <= smooth_wdata;
      end
      if (s_re) begin
         s_rdata_ff <= smooth_mem[req_addr];
      end
   end

   // The result is held in the output register, so the next beat can be taken
   // while an earlier result still waits on the master side.
   assign rsp_load = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      logic        rd_h, rd_n;
      rd_h        = !oob_ff && (cmd_ff == CMD_READ_H);
      rd_n        = !oob_ff && (cmd_ff == CMD_READ_N);
      rsp_data_in = {7'd0,
                     rd_n ? s_rdata_ff : 48'd0,
                     rd_h ? h_rdata_ff : 16'd0,
                     oob_ff};
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Main sequencer.
   always_comb begin
      state_in       = state_ff;
      grid_width_in  = grid_width_ff;
      grid_length_in = grid_length_ff;
      current_in     = current_ff;
      cmd_in         = cmd_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      hin_in         = hin_ff;
      oob_in         = oob_ff;
      x_in           = x_ff;
      z_in           = z_ff;
      nb_in          = nb_ff;
      cj_in          = cj_ff;
      nh_in          = nh_ff;
      acc_in         = acc_ff;
      t_in           = t_ff;

      if (csr_we) begin
         current_in = 1'b0;
         case (csr_addr)
            REG_GRID_WIDTH:  grid_width_in  = csr_wdata;
            REG_GRID_LENGTH: grid_length_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire && req_tdata[1:0] != CMD_NONE) begin
               cmd_in   = req_tdata[1:0];
               col_in   = req_tdata[9:2];
               row_in   = req_tdata[17:10];
               hin_in   = req_tdata[33:18];
               oob_in   = req_oob;
               x_in     = '0;
               z_in     = '0;
               nb_in    = '0;
               if (req_oob) begin
                  state_in = S_RESP;
               end else if (req_tdata[1:0] == CMD_READ_N && !current_ff) begin
                  state_in = S_P1_ADDR;
               end else begin
                  state_in = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            if (cmd_ff == CMD_WRITE) begin
               current_in = 1'b0;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         S_P1_ADDR: state_in = S_P1_DATA;
         S_P1_DATA: begin
            nh_in[nb_ff] = h_rdata_ff;
            if (nb_ff == 3'd4) begin
               nb_in    = '0;
               cj_in    = '0;
               acc_in   = '{default: '0};
               state_in = S_P1_UNIT;
            end else begin
               nb_in    = nb_ff + 3'd1;
               state_in = S_P1_ADDR;
            end
         end
         S_P1_UNIT: begin
            if (corner_ok) begin
               state_in = S_P1_WAIT;
            end else if (cj_ff == 2'd3) begin
               state_in = S_P1_STORE;
            end else begin
               cj_in = cj_ff + 2'd1;
            end
         end
         S_P1_WAIT: begin
            if (unit_done) begin
               acc_in[0] = acc_ff[0] + unit_res.ux;
               acc_in[1] = acc_ff[1] + unit_res.uy;
               acc_in[2] = acc_ff[2] + unit_res.uz;
               if (cj_ff == 2'd3) begin
                  state_in = S_P1_STORE;
               end else begin
                  cj_in    = cj_ff + 2'd1;
                  state_in = S_P1_UNIT;
               end
            end
         end
         S_P1_STORE: begin
            state_in = S_P1_ADDR;
            if (rt_ok) begin
               x_in = x_ff + CW'(1);
            end else begin
               x_in = '0;
               if (dn_ok) begin
                  z_in = z_ff + CW'(1);
               end else begin
                  z_in     = '0;
                  t_in     = '{default: '0};
                  state_in = S_P2_ADDR;
               end
            end
         end
         S_P2_ADDR: state_in = S_P2_DATA;
         S_P2_DATA: begin
            for (int k = 0; k < 3; k++) begin
               if (nb_ff == 3'd0) begin
                  t_in[k] = t_ff[k] + {r_rdata_ff[16*k+15], r_rdata_ff[16*k +: 16], 1'b0};
               end else if (nb_ok) begin
                  t_in[k] = t_ff[k] + 18'($signed(r_rdata_ff[16*k +: 16]));
               end
            end
            if (nb_ff == 3'd4) begin
               nb_in    = '0;
               state_in = S_P2_STORE;
            end else begin
               nb_in    = nb_ff + 3'd1;
               state_in = S_P2_ADDR;
            end
         end
         S_P2_STORE: begin
            t_in     = '{default: '0};
            state_in = S_P2_ADDR;
            if (rt_ok) begin
               x_in = x_ff + CW'(1);
            end else begin
               x_in = '0;
               if (dn_ok) begin
                  z_in = z_ff + CW'(1);
               end else begin
                  z_in       = '0;
                  current_in = 1'b1;
                  state_in   = S_FETCH;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         grid_width_ff  <= GRID_RESET;
         grid_length_ff <= GRID_RESET;
         current_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         x_ff           <= '0;
         z_ff           <= '0;
         nb_ff          <= '0;
         cj_ff          <= '0;
      end else begin
         state_ff       <= state_in;
         grid_width_ff  <= grid_width_in;
         grid_length_ff <= grid_length_in;
         current_ff     <= current_in;
         rsp_valid_ff   <= rsp_valid_in;
         x_ff           <= x_in;
         z_ff           <= z_in;
         nb_ff          <= nb_in;
         cj_ff          <= cj_in;
      end
      cmd_ff <= cmd_in;
      col_ff <= col_in;
      row_ff <= row_in;
      hin_ff <= hin_in;
      oob_ff <= oob_in;
      nh_ff  <= nh_in;
      acc_ff <= acc_in;
      t_ff   <= t_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A result only ever appears from the response state.
   `HMN_ASSERT(a_rsp_from_resp, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == S_RESP))
   // Recompute passes run only while the normals are stale.
   `HMN_ASSERT(a_pass_stale, clock, reset, (state_ff == S_P1_ADDR || state_ff == S_P2_ADDR) |-> !current_ff)
   // A finished corner moves on to the next corner or to the store.
   `HMN_ASSERT_NEXT(a_corner_step, clock, reset, state_ff == S_P1_WAIT && unit_done, state_ff == S_P1_UNIT || state_ff == S_P1_STORE)

endmodule
